// ----- hw/rtl/vcte_pkg.sv -----
`timescale 1ns / 1ps
package vcte_pkg;

	localparam int NUM_FACES = 6;
	localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [31:0] voxel_x;
		logic signed [31:0] voxel_y;
		logic signed [31:0] voxel_z;
		logic [30:0]        edge_size;
		logic [5:0]         face_mask;
	} voxel_t;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
		logic [2:0]         face_normal;
		logic               last_triangle;
	} triangle_t;

	typedef enum logic [2:0] {
		FACE_BOTTOM = 3'd0,
		FACE_FRONT  = 3'd1,
		FACE_BACK   = 3'd2,
		FACE_TOP    = 3'd3,
		FACE_LEFT   = 3'd4,
		FACE_RIGHT  = 3'd5
	} face_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic emit;
		logic second;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mask_nz;
		logic out_free;
		logic last_face;
	} dp_status_t;

	// corner indices of the two triangles of each face, first vertex in [8:6]
	function automatic logic [8:0] face_corners(input logic [2:0] face, input logic second);
		logic [8:0] r;
		r = 9'd0;
		unique case ({face, second})
			{FACE_BOTTOM, 1'b0}: r = {3'd0, 3'd3, 3'd1};
			{FACE_BOTTOM, 1'b1}: r = {3'd1, 3'd3, 3'd2};
			{FACE_FRONT, 1'b0}:  r = {3'd0, 3'd5, 3'd4};
			{FACE_FRONT, 1'b1}:  r = {3'd0, 3'd1, 3'd5};
			{FACE_BACK, 1'b0}:   r = {3'd3, 3'd7, 3'd6};
			{FACE_BACK, 1'b1}:   r = {3'd3, 3'd6, 3'd2};
			{FACE_TOP, 1'b0}:    r = {3'd4, 3'd5, 3'd7};
			{FACE_TOP, 1'b1}:    r = {3'd5, 3'd6, 3'd7};
			{FACE_LEFT, 1'b0}:   r = {3'd0, 3'd7, 3'd3};
			{FACE_LEFT, 1'b1}:   r = {3'd0, 3'd4, 3'd7};
			{FACE_RIGHT, 1'b0}:  r = {3'd1, 3'd6, 3'd5};
			{FACE_RIGHT, 1'b1}:  r = {3'd1, 3'd2, 3'd6};
			default:             r = 9'd0;
		endcase
		return r;
	endfunction

	// index of the lowest set bit of a face mask
	function automatic logic [2:0] lowest_face(input logic [5:0] mask);
		logic [2:0] r;
		r = 3'd0;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (mask[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	// origin plus edge, clipped to the top of the coordinate range
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
			input logic [30:0] edge_len);
		logic [32:0] s;
		s = {base[31], base} + {2'b00, edge_len};
		if (s[32:31] == 2'b01) begin
			return COORD_MAX;
		end
		return s[31:0];
	endfunction

endpackage

// ----- hw/rtl/vcte_ctrl.sv -----
`timescale 1ns / 1ps
module vcte_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  voxel_valid,
	output logic                  voxel_ready,
	input  vcte_pkg::dp_status_t  status,
	output vcte_pkg::dp_cmd_t     cmd
);
	import vcte_pkg::*;

	state_t state_q, state_d;
	logic   second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		second_d    = second_q;
		voxel_ready = 1'b0;
		cmd.load    = 1'b0;
		cmd.emit    = 1'b0;
		cmd.second  = second_q;
		unique case (state_q)
			ST_IDLE: begin
				voxel_ready = 1'b1;
				second_d    = 1'b0;
				if (voxel_valid) begin
					cmd.load = 1'b1;
					// an empty mask makes no triangles
					if (status.mask_nz) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					second_d = ~second_q;
					if (second_q && status.last_face) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/vcte_dp.sv -----
`timescale 1ns / 1ps
module vcte_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vcte_pkg::voxel_t      voxel,
	output vcte_pkg::triangle_t   triangle,
	output logic                  triangle_valid,
	input  logic                  triangle_ready,
	input  vcte_pkg::dp_cmd_t     cmd,
	output vcte_pkg::dp_status_t  status
);
	import vcte_pkg::*;

	logic signed [31:0] ox_q, oy_q, oz_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [5:0]         rem_q;
	triangle_t          out_q;
	logic               out_valid_q;

	logic [2:0]         face;
	logic [8:0]         corners;
	logic [2:0]         ca, cb, cc;
	triangle_t          tri_d;
	logic               last_face;

	// origin and far corner coordinates of the current voxel
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ox_q <= voxel.voxel_x;
			oy_q <= voxel.voxel_y;
			oz_q <= voxel.voxel_z;
			px_q <= sat_add(voxel.voxel_x, voxel.edge_size);
			py_q <= sat_add(voxel.voxel_y, voxel.edge_size);
			pz_q <= sat_add(voxel.voxel_z, voxel.edge_size);
		end
	end

	// faces still to visit; lowest one drops after its second triangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 6'd0;
		end else if (cmd.load) begin
			rem_q <= voxel.face_mask;
		end else if (cmd.emit && cmd.second) begin
			rem_q <= rem_q & (rem_q - 6'd1);
		end
	end

	assign face      = lowest_face(rem_q);
	assign corners   = face_corners(face, cmd.second);
	assign ca        = corners[8:6];
	assign cb        = corners[5:3];
	assign cc        = corners[2:0];
	assign last_face = ((rem_q & (rem_q - 6'd1)) == 6'd0);

	always_comb begin
		tri_d.a_x = (ca[0] ^ ca[1]) ? px_q : ox_q;
		tri_d.a_y = ca[1] ? py_q : oy_q;
		tri_d.a_z = ca[2] ? pz_q : oz_q;
		tri_d.b_x = (cb[0] ^ cb[1]) ? px_q : ox_q;
		tri_d.b_y = cb[1] ? py_q : oy_q;
		tri_d.b_z = cb[2] ? pz_q : oz_q;
		tri_d.c_x = (cc[0] ^ cc[1]) ? px_q : ox_q;
		tri_d.c_y = cc[1] ? py_q : oy_q;
		tri_d.c_z = cc[2] ? pz_q : oz_q;
		tri_d.face_normal   = face;
		tri_d.last_triangle = cmd.second && last_face;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= tri_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (triangle_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign triangle         = out_q;
	assign triangle_valid   = out_valid_q;
	assign status.mask_nz   = (voxel.face_mask != 6'd0);
	assign status.out_free  = !out_valid_q || triangle_ready;
	assign status.last_face = last_face;

endmodule

// ----- hw/rtl/voxel_cube_triangle_emitter.sv -----
`timescale 1ns / 1ps
// channel    payload     handshake
// voxel      voxel_t     voxel_valid / voxel_ready
// triangle   triangle_t  triangle_valid / triangle_ready
//
// a voxel with n enabled faces loads its corners, then gives 2n triangles, one per cycle
// while the output is not stalled, from a single output register
// an empty mask is loaded and gives nothing
// the next voxel is taken while the last triangle still waits in the output register
// a stalled output holds the emitter; arst_n clears the controller and output valid
module voxel_cube_triangle_emitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 voxel_valid,
	output logic                 voxel_ready,
	input  vcte_pkg::voxel_t     voxel,
	output logic                 triangle_valid,
	input  logic                 triangle_ready,
	output vcte_pkg::triangle_t  triangle
);
	import vcte_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	vcte_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.voxel_valid (voxel_valid),
		.voxel_ready (voxel_ready),
		.status      (status),
		.cmd         (cmd)
	);

	vcte_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.voxel          (voxel),
		.triangle       (triangle),
		.triangle_valid (triangle_valid),
		.triangle_ready (triangle_ready),
		.cmd            (cmd),
		.status         (status)
	);

endmodule

// ----- hw/rtl/vcte_chk.sv -----
`timescale 1ns / 1ps
module vcte_chk (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 voxel_ready,
	input  logic                 triangle_valid,
	input  logic                 triangle_ready,
	input  vcte_pkg::triangle_t  triangle
);
	import vcte_pkg::*;

	// a stalled triangle holds
	assert property (@(posedge clk) disable iff (!arst_n)
		triangle_valid && !triangle_ready |=> triangle_valid && $stable(triangle))
		else $error("stalled triangle changed");

	// no new voxel while the current one still has triangles to come
	assert property (@(posedge clk) disable iff (!arst_n)
		triangle_valid && !triangle.last_triangle |-> !voxel_ready)
		else $error("voxel taken mid-run");

	// bottom and top faces are flat in z
	assert property (@(posedge clk) disable iff (!arst_n)
		triangle_valid && (triangle.face_normal == FACE_BOTTOM
			|| triangle.face_normal == FACE_TOP)
		|-> triangle.a_z == triangle.b_z && triangle.b_z == triangle.c_z)
		else $error("z face not flat");

	// left and right faces are flat in x
	assert property (@(posedge clk) disable iff (!arst_n)
		triangle_valid && (triangle.face_normal == FACE_LEFT
			|| triangle.face_normal == FACE_RIGHT)
		|-> triangle.a_x == triangle.b_x && triangle.b_x == triangle.c_x)
		else $error("x face not flat");

endmodule

bind voxel_cube_triangle_emitter vcte_chk u_vcte_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.voxel_ready    (voxel_ready),
	.triangle_valid (triangle_valid),
	.triangle_ready (triangle_ready),
	.triangle       (triangle)
);

// ----- dv/voxel_triangle_checker.sv -----
`timescale 1ns / 1ps
module voxel_triangle_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                voxel_valid,
	input  logic                voxel_ready,
	input  vcte_pkg::voxel_t    voxel,
	input  logic                triangle_valid,
	input  logic                triangle_ready,
	input  vcte_pkg::triangle_t triangle,
	output int                  mismatches,
	output int                  outstanding,
	output int                  voxels_taken,
	output int                  triangles_checked
);
	import vcte_pkg::*;

	// corners of each triangle, faces in visiting order, two triangles per face
	localparam logic [0:5][0:1][0:2][2:0] TRI_CORNERS = {
		3'd0, 3'd3, 3'd1,  3'd1, 3'd3, 3'd2,
		3'd0, 3'd5, 3'd4,  3'd0, 3'd1, 3'd5,
		3'd3, 3'd7, 3'd6,  3'd3, 3'd6, 3'd2,
		3'd4, 3'd5, 3'd7,  3'd5, 3'd6, 3'd7,
		3'd0, 3'd7, 3'd3,  3'd0, 3'd4, 3'd7,
		3'd1, 3'd6, 3'd5,  3'd1, 3'd2, 3'd6
	};

	triangle_t expected_tris[$];

	function automatic logic signed [31:0] clip_sum(input logic signed [31:0] base,
			input logic [30:0] len);
		longint s;
		s = longint'(base) + longint'(len);
		if (s > longint'(COORD_MAX)) begin
			return COORD_MAX;
		end
		return 32'(s);
	endfunction

	task automatic queue_triangles(input voxel_t v);
		logic signed [31:0] px [8];
		logic signed [31:0] py [8];
		logic signed [31:0] pz [8];
		triangle_t t;
		logic [2:0] c;
		int total;
		int n;
		total = 2 * $countones(v.face_mask);
		n = 0;
		// corner k: x from bit0 xor bit1, y from bit1, z from bit2
		for (int k = 0; k < 8; k++) begin
			px[k] = (k[0] ^ k[1]) ? clip_sum(v.voxel_x, v.edge_size) : v.voxel_x;
			py[k] = k[1] ? clip_sum(v.voxel_y, v.edge_size) : v.voxel_y;
			pz[k] = k[2] ? clip_sum(v.voxel_z, v.edge_size) : v.voxel_z;
		end
		for (int f = 0; f < NUM_FACES; f++) begin
			if (v.face_mask[f]) begin
				for (int s = 0; s < 2; s++) begin
					c = TRI_CORNERS[f][s][0];
					t.a_x = px[c];
					t.a_y = py[c];
					t.a_z = pz[c];
					c = TRI_CORNERS[f][s][1];
					t.b_x = px[c];
					t.b_y = py[c];
					t.b_z = pz[c];
					c = TRI_CORNERS[f][s][2];
					t.c_x = px[c];
					t.c_y = py[c];
					t.c_z = pz[c];
					t.face_normal = face_t'(f);
					n++;
					t.last_triangle = (n == total);
					expected_tris.push_back(t);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: triangle %0d %s expected %0d got %0d", $time,
				triangles_checked, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// the output is registered, so a triangle never belongs to a voxel taken at this edge
			if (triangle_valid && triangle_ready) begin
				if (expected_tris.size() == 0) begin
					mismatches++;
					$display("%0t: triangle %0d expected none got face %0d last %0b", $time,
						triangles_checked, triangle.face_normal, triangle.last_triangle);
				end else begin
					triangle_t want;
					want = expected_tris.pop_front();
					check_field("a_x", want.a_x, triangle.a_x);
					check_field("a_y", want.a_y, triangle.a_y);
					check_field("a_z", want.a_z, triangle.a_z);
					check_field("b_x", want.b_x, triangle.b_x);
					check_field("b_y", want.b_y, triangle.b_y);
					check_field("b_z", want.b_z, triangle.b_z);
					check_field("c_x", want.c_x, triangle.c_x);
					check_field("c_y", want.c_y, triangle.c_y);
					check_field("c_z", want.c_z, triangle.c_z);
					check_field("face_normal", want.face_normal, triangle.face_normal);
					check_field("last_triangle", want.last_triangle, triangle.last_triangle);
				end
				triangles_checked++;
			end
			if (voxel_valid && voxel_ready) begin
				queue_triangles(voxel);
				voxels_taken++;
			end
			outstanding <= expected_tris.size();
		end
	end

endmodule

// ----- dv/tb_voxel_cube_triangle_emitter.sv -----
`timescale 1ns / 1ps
module tb_voxel_cube_triangle_emitter;
	import vcte_pkg::*;

	localparam int IDLE_PCT = 7;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
	localparam logic [30:0] EDGE_MAX = 31'h7fff_ffff;
	localparam logic [30:0] EDGE_ONE = 31'h0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic voxel_valid = 1'b0;
	logic voxel_ready;
	voxel_t voxel = '0;
	logic triangle_valid;
	logic triangle_ready = 1'b0;
	triangle_t triangle;

	int mismatches;
	int outstanding;
	int voxels_taken;
	int triangles_checked;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;

	voxel_cube_triangle_emitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.voxel_valid(voxel_valid),
		.voxel_ready(voxel_ready),
		.voxel(voxel),
		.triangle_valid(triangle_valid),
		.triangle_ready(triangle_ready),
		.triangle(triangle)
	);

	voxel_triangle_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.voxel_valid(voxel_valid),
		.voxel_ready(voxel_ready),
		.voxel(voxel),
		.triangle_valid(triangle_valid),
		.triangle_ready(triangle_ready),
		.triangle(triangle),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.voxels_taken(voxels_taken),
		.triangles_checked(triangles_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic voxel_t make_voxel(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic [30:0] len, input logic [5:0] mask);
		voxel_t v;
		v.voxel_x = x;
		v.voxel_y = y;
		v.voxel_z = z;
		v.edge_size = len;
		v.face_mask = mask;
		return v;
	endfunction

	// mix of small values and values near both ends of the range
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return 32'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
			1: return COORD_MAX - 32'($urandom_range(32'h0002_0000));
			2: return COORD_MIN + 32'($urandom_range(32'h0002_0000));
			default: return $urandom;
		endcase
	endfunction

	function automatic voxel_t rand_voxel();
		logic [30:0] len;
		logic [5:0] mask;
		case ($urandom_range(3))
			0: len = 31'($urandom_range(32'h0004_0000));
			1: len = EDGE_MAX - 31'($urandom_range(255));
			default: len = 31'($urandom);
		endcase
		case ($urandom_range(9))
			0: mask = '0;
			1: mask = '1;
			default: mask = 6'($urandom);
		endcase
		return make_voxel(rand_coord(), rand_coord(), rand_coord(), len, mask);
	endfunction

	task automatic offer_voxel(input voxel_t v);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			voxel_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		voxel <= v;
		voxel_valid <= 1'b1;
		@(posedge clk);
		while (!voxel_ready) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) offer_voxel(rand_voxel());
	endtask

	task automatic drain_results();
		voxel_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				triangle_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				triangle_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((voxel_valid && voxel_ready) || (triangle_valid && triangle_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		offer_voxel(make_voxel(0, 0, 0, EDGE_ONE, '0));
		for (int f = FACE_BOTTOM; f <= FACE_RIGHT; f++) begin
			offer_voxel(make_voxel(rand_coord(), rand_coord(), rand_coord(), EDGE_ONE,
				6'b1 << f));
		end
		offer_voxel(make_voxel(0, 0, 0, '0, '1));
		// all corners clip to the top of the range
		offer_voxel(make_voxel(COORD_MAX, COORD_MAX, COORD_MAX, EDGE_MAX, '1));
		offer_voxel(make_voxel(COORD_MIN, COORD_MIN, COORD_MIN, EDGE_MAX, '1));
		// exactly at the limit, one over, two over
		offer_voxel(make_voxel(32'sh7ffe_ffff, 32'sh7fff_0000, 32'sh7fff_0001, EDGE_ONE, '1));
		offer_voxel(make_voxel(32'sh5555_5555, 32'shaaaa_aaaa, -1, 31'h2aaa_aaaa, 6'h15));
		offer_voxel(make_voxel(32'shaaaa_aaaa, 32'sh5555_5555, 0, 31'h5555_5555, 6'h2a));
		offer_voxel(make_voxel(32'shffff_0000, 32'sh0001_0000, COORD_MAX, '0,
			(6'b1 << FACE_BOTTOM) | (6'b1 << FACE_RIGHT)));
		// empty masks back to back
		offer_voxel(make_voxel(COORD_MIN, 0, COORD_MAX, EDGE_MAX, '0));
		offer_voxel(make_voxel(-1, -1, -1, EDGE_MAX, '0));
		offer_voxel(make_voxel(0, COORD_MAX, 0, EDGE_MAX,
			(6'b1 << FACE_TOP) | (6'b1 << FACE_LEFT)));

		send_random(200);

		calm = 1'b1;
		send_random(120);
		calm = 1'b0;

		// long output stall while new voxels keep coming
		hold_done = 1'b0;
		hold_request = 1'b1;
		while (!hold_done) offer_voxel(rand_voxel());
		hold_request = 1'b0;
		send_random(10);

		drain_results();
		send_random(140);

		drain_results();
		repeat (30) @(posedge clk);
		$display("%0d voxels taken, %0d triangles checked", voxels_taken, triangles_checked);
		$display("faces alone and together, empty masks, clipped corners, long stall, pause");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- voxel_cube_triangle_emitter.f -----
hw/rtl/vcte_pkg.sv
hw/rtl/vcte_ctrl.sv
hw/rtl/vcte_dp.sv
hw/rtl/voxel_cube_triangle_emitter.sv
hw/rtl/vcte_chk.sv
dv/voxel_triangle_checker.sv
dv/tb_voxel_cube_triangle_emitter.sv
